/* hw/rtl/gbn_pkg.sv */
`default_nettype none
package gbn_pkg;

	localparam int SEQ_SPACE  = 16;
	localparam int SEQ_W      = $clog2(SEQ_SPACE);
	localparam int DATA_WIDTH = 64;
	localparam int PAYLOAD_W  = 64;
	localparam int CFG_W      = 4;
	localparam int TAG_W      = 4;
	localparam int MAX_WIN    = SEQ_SPACE - 1;
	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(4);

	localparam logic [1:0] FUNC_SEND    = 2'd0;
	localparam logic [1:0] FUNC_ACK     = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	typedef logic [SEQ_W-1:0] seq_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ACK2   = 3'b010,
		ST_RESEND = 3'b100
	} state_t;

	// one result record, minus the packet data
	typedef struct packed {
		logic accepted;
		logic packet_valid;
		seq_t packet_seq;
		logic timer_stop;
		logic timer_start;
		logic [TAG_W-1:0] timer_seq;
		logic window_full;
		logic last;
		logic from_ram;
	} res_t;

	typedef struct packed {
		logic we;
		seq_t waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic re;
		seq_t raddr;
	} ram_req_t;

endpackage
`default_nettype wire

/* hw/rtl/gbn_if.sv */
`default_nettype none
interface gbn_req_if;
	import gbn_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [PAYLOAD_W-1:0] payload;
	logic [SEQ_W-1:0] ack_number;
	logic ack_checksum_ok;
	logic [TAG_W-1:0] timer_tag;

	modport source (output valid, func, payload, ack_number, ack_checksum_ok, timer_tag,
		input ready);
	modport sink (input valid, func, payload, ack_number, ack_checksum_ok, timer_tag,
		output ready);
endinterface

interface gbn_rsp_if;
	import gbn_pkg::*;
	logic valid;
	logic ready;
	logic accepted;
	logic packet_valid;
	logic [SEQ_W-1:0] packet_seq;
	logic [PAYLOAD_W-1:0] packet_data;
	logic timer_stop;
	logic timer_start;
	logic [TAG_W-1:0] timer_seq;
	logic window_full;
	logic last;

	modport source (output valid, accepted, packet_valid, packet_seq, packet_data,
		timer_stop, timer_start, timer_seq, window_full, last, input ready);
	modport sink (input valid, accepted, packet_valid, packet_seq, packet_data,
		timer_stop, timer_start, timer_seq, window_full, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gbn_ram.sv */
`default_nettype none
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data when no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/gbn_ctrl.sv */
`default_nettype none
module gbn_ctrl import gbn_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	gbn_req_if.sink                    req,
	gbn_rsp_if.source                  rsp,
	output      ram_req_t              ram_req,
	input  wire logic [DATA_WIDTH-1:0] ram_rdata
);

	state_t state_q, state_n;
	seq_t base_q, base_n;
	seq_t next_q, next_n;
	logic full_q, full_n;
	logic [CFG_W-1:0] wsize_q;
	logic [TAG_W-1:0] tag_q, tag_n;
	seq_t ptr_q, ptr_n;
	seq_t rem_q, rem_n;

	logic s1_valid_q;
	res_t res_s1;
	logic [DATA_WIDTH-1:0] data_s1;

	logic out_valid_q;
	res_t out_res_q;
	logic [PAYLOAD_W-1:0] out_data_q;

	logic out_free, issue_ok, accept, issue;
	res_t res_n;
	logic [DATA_WIDTH-1:0] data_n;
	seq_t eff_win, outst, outst_after, ack_off, ack_next;
	logic in_range;

	assign out_free = !out_valid_q || rsp.ready;
	assign issue_ok = !s1_valid_q || out_free;
	assign req.ready = (state_q == ST_IDLE) && issue_ok;
	assign accept = req.valid && req.ready;

	always_comb begin
		if (wsize_q == '0) begin
			eff_win = seq_t'(1);
		end else if ({1'b0, wsize_q} > (CFG_W+1)'(MAX_WIN)) begin
			eff_win = seq_t'(MAX_WIN);
		end else begin
			eff_win = seq_t'(wsize_q);
		end
	end

	assign outst       = next_q - base_q;
	assign outst_after = next_q + seq_t'(1) - base_q;
	assign ack_off     = seq_t'(req.ack_number) - base_q;
	assign ack_next    = seq_t'(req.ack_number) + seq_t'(1);
	assign in_range    = req.ack_checksum_ok && (ack_off < outst);

	always_comb begin
		state_n = state_q;
		base_n  = base_q;
		next_n  = next_q;
		full_n  = full_q;
		tag_n   = tag_q;
		ptr_n   = ptr_q;
		rem_n   = rem_q;
		issue   = 1'b0;
		res_n   = '0;
		res_n.window_full = full_q;
		res_n.last = 1'b1;
		data_n  = '0;
		ram_req = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					issue = 1'b1;
					unique case (req.func)
						FUNC_SEND: begin
							if (!full_q) begin
								ram_req.we    = 1'b1;
								ram_req.waddr = next_q;
								ram_req.wdata = DATA_WIDTH'(req.payload);
								next_n = next_q + seq_t'(1);
								full_n = outst_after >= eff_win;
								data_n = DATA_WIDTH'(req.payload);
								res_n.accepted     = 1'b1;
								res_n.packet_valid = 1'b1;
								res_n.packet_seq   = next_q;
								if (next_q == base_q) begin
									res_n.timer_start = 1'b1;
									res_n.timer_seq   = TAG_W'(next_q);
								end
								res_n.window_full = full_n;
							end
						end
						FUNC_ACK: begin
							if (in_range) begin
								base_n = ack_next;
								full_n = 1'b0;
								res_n.timer_stop  = 1'b1;
								res_n.timer_seq   = TAG_W'(base_q);
								res_n.window_full = 1'b0;
								// restart the timer in a second transaction
								if (ack_next != next_q) begin
									res_n.last = 1'b0;
									state_n = ST_ACK2;
								end
							end
						end
						FUNC_TIMEOUT: begin
							res_n.timer_stop = 1'b1;
							res_n.timer_seq  = req.timer_tag;
							if (outst == '0) begin
								res_n.timer_start = 1'b1;
							end else begin
								ram_req.re    = 1'b1;
								ram_req.raddr = base_q;
								res_n.packet_valid = 1'b1;
								res_n.packet_seq   = base_q;
								res_n.from_ram     = 1'b1;
								res_n.timer_start  = (outst == seq_t'(1));
								res_n.last         = (outst == seq_t'(1));
								tag_n = req.timer_tag;
								ptr_n = base_q + seq_t'(1);
								rem_n = outst - seq_t'(1);
								if (outst != seq_t'(1)) begin
									state_n = ST_RESEND;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ACK2: begin
				if (issue_ok) begin
					issue = 1'b1;
					res_n.timer_start = 1'b1;
					res_n.timer_seq   = TAG_W'(base_q);
					state_n = ST_IDLE;
				end
			end
			ST_RESEND: begin
				if (issue_ok) begin
					issue = 1'b1;
					ram_req.re    = 1'b1;
					ram_req.raddr = ptr_q;
					res_n.packet_valid = 1'b1;
					res_n.packet_seq   = ptr_q;
					res_n.from_ram     = 1'b1;
					res_n.timer_seq    = tag_q;
					res_n.timer_start  = (rem_q == seq_t'(1));
					res_n.last         = (rem_q == seq_t'(1));
					ptr_n = ptr_q + seq_t'(1);
					rem_n = rem_q - seq_t'(1);
					if (rem_q == seq_t'(1)) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			full_q      <= 1'b0;
			wsize_q     <= WIN_RESET;
			tag_q       <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			base_q  <= base_n;
			next_q  <= next_n;
			full_q  <= full_n;
			tag_q   <= tag_n;
			ptr_q   <= ptr_n;
			rem_q   <= rem_n;
			if (cfg_we) begin
				wsize_q <= cfg_wdata;
			end
			if (issue_ok) begin
				s1_valid_q <= issue;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// read data stays on the RAM port until the record in s1 moves on
	always_ff @(posedge clk) begin
		if (issue) begin
			res_s1  <= res_n;
			data_s1 <= data_n;
		end
		if (out_free && s1_valid_q) begin
			out_res_q <= res_s1;
			if (!res_s1.packet_valid) begin
				out_data_q <= '0;
			end else if (res_s1.from_ram) begin
				out_data_q <= PAYLOAD_W'(ram_rdata);
			end else begin
				out_data_q <= PAYLOAD_W'(data_s1);
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.accepted     = out_res_q.accepted;
	assign rsp.packet_valid = out_res_q.packet_valid;
	assign rsp.packet_seq   = out_res_q.packet_seq;
	assign rsp.packet_data  = out_data_q;
	assign rsp.timer_stop   = out_res_q.timer_stop;
	assign rsp.timer_start  = out_res_q.timer_start;
	assign rsp.timer_seq    = out_res_q.timer_seq;
	assign rsp.window_full  = out_res_q.window_full;
	assign rsp.last         = out_res_q.last;

endmodule
`default_nettype wire

/* hw/rtl/go_back_n_sender.sv */
// channel   dir  handshake     payload
// req       in   valid/ready   func, payload, ack_number, ack_checksum_ok, timer_tag
// rsp       out  valid/ready   accepted, packet_*, timer_*, window_full, last
// cfg       in   cfg_we        cfg_wdata -> window_size
//
// Send, rejected ack and unknown events: one response. Accepted ack: one response, two if
// the timer is restarted. Timeout: max(1, outstanding) responses, one packet store read
// per resent packet through the single RAM read port.
// Reset clears window base, next sequence, full flag and window size (4); the packet
// store is not cleared. A stalled rsp holds the output register and the read stage.
`default_nettype none
module go_back_n_sender import gbn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	gbn_req_if.sink               req,
	gbn_rsp_if.source             rsp
);

	ram_req_t ram_req;
	logic [DATA_WIDTH-1:0] ram_rdata;

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	gbn_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (SEQ_SPACE)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("packet store read and written in one cycle");

	a_write_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (req.valid && req.ready && req.func == FUNC_SEND))
		else $error("packet store written without a send transaction");

	a_data_zero_no_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.packet_valid) |-> (rsp.packet_data == '0))
		else $error("packet data set without a packet");

	// resent packets carry the timer tag on every transaction of the burst
	a_tseq_zero_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.packet_valid && !rsp.timer_stop && !rsp.timer_start)
		|-> (rsp.timer_seq == '0))
		else $error("timer tag set without a timer request");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import gbn_pkg::*;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]           func;
		logic [PAYLOAD_W-1:0] payload;
		seq_t                 ack_number;
		logic                 ack_ok;
		logic [TAG_W-1:0]     tag;
	} win_event_t;

	typedef struct packed {
		logic                 accepted;
		logic                 packet_valid;
		seq_t                 packet_seq;
		logic [PAYLOAD_W-1:0] packet_data;
		logic                 timer_stop;
		logic                 timer_start;
		logic [TAG_W-1:0]     timer_seq;
		logic                 window_full;
		logic                 last;
	} rsp_rec_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	gbn_req_if req ();
	gbn_rsp_if rsp ();

	go_back_n_sender u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// shadow of the sender window
	logic [CFG_W-1:0]      m_win = WIN_RESET;
	seq_t                  m_base = '0;
	seq_t                  m_next = '0;
	logic                  m_full = 1'b0;
	logic [DATA_WIDTH-1:0] m_store [SEQ_SPACE];

	rsp_rec_t rsp_due [$];
	rsp_rec_t got, want;

	bit quiet = 0;
	int fail_count = 0;
	int idle_cnt = 0;
	int stall_left = 0;
	int rdy_gap;
	int cur_burst = 0;
	int max_burst = 0;
	int n_items = 0, n_results = 0, n_cfg = 0;
	int n_sent = 0, n_refused = 0, n_slides = 0, n_timeouts = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic string show(rsp_rec_t r);
		return $sformatf({"acc=%0b pv=%0b seq=%0d data=%h stop=%0b start=%0b",
			" tseq=%0d full=%0b last=%0b"},
			r.accepted, r.packet_valid, r.packet_seq, r.packet_data, r.timer_stop,
			r.timer_start, r.timer_seq, r.window_full, r.last);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	function automatic win_event_t mk(input logic [1:0] func, input logic [PAYLOAD_W-1:0] payload,
		input seq_t ack_number, input logic ack_ok, input logic [TAG_W-1:0] tag);
		win_event_t ev;
		ev.func = func;
		ev.payload = payload;
		ev.ack_number = ack_number;
		ev.ack_ok = ack_ok;
		ev.tag = tag;
		return ev;
	endfunction

	// apply one event to the shadow window and queue the responses it produces
	task automatic window_step(input win_event_t ev);
		rsp_rec_t r;
		rsp_rec_t burst [$];
		seq_t cnt, s, old_base;
		logic was_empty;
		int w;
		cnt = m_next - m_base;
		case (ev.func)
			FUNC_SEND: begin
				r = '0;
				if (m_full) begin
					n_refused++;
				end else begin
					was_empty = (m_next == m_base);
					s = m_next;
					m_store[s] = ev.payload[DATA_WIDTH-1:0];
					m_next = m_next + 1'b1;
					w = (m_win == 0) ? 1 : int'(m_win);
					if (w > MAX_WIN)
						w = MAX_WIN;
					if (int'(seq_t'(m_next - m_base)) >= w)
						m_full = 1'b1;
					r.accepted = 1'b1;
					r.packet_valid = 1'b1;
					r.packet_seq = s;
					r.packet_data = PAYLOAD_W'(m_store[s]);
					r.timer_start = was_empty;
					r.timer_seq = was_empty ? TAG_W'(s) : '0;
					n_sent++;
				end
				burst.push_back(r);
			end
			FUNC_ACK: begin
				r = '0;
				if (ev.ack_ok && seq_t'(ev.ack_number - m_base) < cnt) begin
					old_base = m_base;
					m_base = ev.ack_number + 1'b1;
					m_full = 1'b0;
					r.timer_stop = 1'b1;
					r.timer_seq = TAG_W'(old_base);
					burst.push_back(r);
					if (m_base != m_next) begin
						r = '0;
						r.timer_start = 1'b1;
						r.timer_seq = TAG_W'(m_base);
						burst.push_back(r);
					end
					n_slides++;
				end else begin
					burst.push_back(r);
				end
			end
			FUNC_TIMEOUT: begin
				n_timeouts++;
				if (cnt == 0) begin
					r = '0;
					r.timer_stop = 1'b1;
					r.timer_start = 1'b1;
					r.timer_seq = ev.tag;
					burst.push_back(r);
				end else begin
					for (int i = 0; i < int'(cnt); i++) begin
						s = m_base + seq_t'(i);
						r = '0;
						r.packet_valid = 1'b1;
						r.packet_seq = s;
						r.packet_data = PAYLOAD_W'(m_store[s]);
						r.timer_stop = (i == 0);
						r.timer_start = (i == int'(cnt) - 1);
						r.timer_seq = ev.tag;
						burst.push_back(r);
					end
				end
			end
			default: begin
				r = '0;
				burst.push_back(r);
			end
		endcase
		foreach (burst[k]) begin
			burst[k].window_full = m_full;
			burst[k].last = (k == burst.size() - 1);
			rsp_due.push_back(burst[k]);
		end
	endtask

	// mostly well-formed traffic, driven by the shadow window
	function automatic win_event_t random_event();
		win_event_t ev;
		int r;
		seq_t cnt;
		ev = mk(FUNC_SEND, {$urandom, $urandom}, seq_t'($urandom), 1'b1, TAG_W'($urandom));
		cnt = m_next - m_base;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			ev.func = FUNC_SEND;
		end else if (r < 75) begin
			if (cnt != 0) begin
				ev.func = FUNC_ACK;
				ev.ack_number = m_base + seq_t'($urandom_range(0, int'(cnt) - 1));
			end
		end else if (r < 88) begin
			ev.func = FUNC_TIMEOUT;
		end else if (r < 93) begin
			ev.func = FUNC_ACK;
			ev.ack_ok = 1'b0;
		end else if (r < 97) begin
			ev.func = FUNC_ACK;
		end else begin
			ev.func = FUNC_UNKNOWN;
			ev.ack_ok = 1'($urandom_range(0, 1));
		end
		return ev;
	endfunction

	task automatic send_event(input win_event_t ev);
		int gap;
		logic taken;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= ev.func;
		req.payload <= ev.payload;
		req.ack_number <= ev.ack_number;
		req.ack_checksum_ok <= ev.ack_ok;
		req.timer_tag <= ev.tag;
		// sample ready once it has settled ahead of the next rising edge
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end
		window_step(ev);
		n_items++;
	endtask

	task automatic quiesce();
		req.valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		m_win = v;
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	task automatic test_reset_defaults();
		send_event(mk(FUNC_TIMEOUT, '0, '0, 1'b1, '1));
		send_event(mk(FUNC_ACK, '0, '0, 1'b1, '0));
		send_event(mk(FUNC_SEND, '1, '1, 1'b0, '1));
		send_event(mk(FUNC_SEND, '0, '0, 1'b1, '0));
		send_event(mk(FUNC_ACK, '1, '0, 1'b0, '0));
		send_event(mk(FUNC_ACK, '0, '1, 1'b1, '0));
		// fill the reset-size window, then bounce off it
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_TIMEOUT, '1, '1, 1'b0, '0));
		send_event(mk(FUNC_ACK, '0, m_base + 1'b1, 1'b1, '1));
		send_event(mk(FUNC_UNKNOWN, '1, '1, 1'b1, '1));
		send_event(mk(FUNC_ACK, '0, m_next - 1'b1, 1'b1, '0));
		quiesce();
	endtask

	task automatic test_window_limits();
		write_window('0);
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_ACK, '0, m_next - 1'b1, 1'b1, '0));
		quiesce();
		write_window(CFG_W'(1));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_TIMEOUT, '0, '0, 1'b0, TAG_W'(5)));
		send_event(mk(FUNC_ACK, '0, m_next - 1'b1, 1'b1, '0));
		quiesce();
	endtask

	task automatic test_window_shrink();
		write_window(CFG_W'(8));
		repeat (5) send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		quiesce();
		// full flag stays clear until the next taken send
		write_window(CFG_W'(2));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_SEND, {$urandom, $urandom}, '0, 1'b0, '0));
		send_event(mk(FUNC_ACK, '0, m_next - 1'b1, 1'b1, '0));
		quiesce();
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] wins [6];
		wins[0] = CFG_W'(MAX_WIN);
		wins[1] = CFG_W'($urandom_range(2, 14));
		wins[2] = CFG_W'(1);
		wins[3] = CFG_W'(MAX_WIN);
		wins[4] = CFG_W'($urandom_range(2, 14));
		wins[5] = '0;
		for (int p = 0; p < 6; p++) begin
			quiesce();
			write_window(wins[p]);
			quiet = (p == 2);
			// fill the window so the timeout resends a full burst
			while (!m_full)
				send_event(mk(FUNC_SEND, {$urandom, $urandom}, seq_t'($urandom), 1'b0, '0));
			send_event(mk(FUNC_TIMEOUT, {$urandom, $urandom}, seq_t'($urandom), 1'b1,
				TAG_W'($urandom)));
			for (int k = 0; k < 36; k++)
				send_event(random_event());
		end
		quiet = 0;
	endtask

	// response side: random backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rdy_gap = pick_gap();
			if (rdy_gap == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b0;
				stall_left <= rdy_gap - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			got.accepted = rsp.accepted;
			got.packet_valid = rsp.packet_valid;
			got.packet_seq = rsp.packet_seq;
			got.packet_data = rsp.packet_data;
			got.timer_stop = rsp.timer_stop;
			got.timer_start = rsp.timer_start;
			got.timer_seq = rsp.timer_seq;
			got.window_full = rsp.window_full;
			got.last = rsp.last;
			n_results++;
			cur_burst++;
			if (got.last) begin
				if (cur_burst > max_burst)
					max_burst = cur_burst;
				cur_burst = 0;
			end
			if (rsp_due.size() == 0) begin
				note_failure($sformatf("unexpected response: %s", show(got)));
			end else begin
				want = rsp_due.pop_front();
				if (got !== want)
					note_failure($sformatf("response mismatch\n  expected %s\n  actual   %s",
						show(want), show(got)));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
	end

	initial begin
		while (idle_cnt < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles, %0d responses pending",
			IDLE_LIMIT, rsp_due.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.func = FUNC_SEND;
		req.payload = '0;
		req.ack_number = '0;
		req.ack_checksum_ok = 1'b0;
		req.timer_tag = '0;
		rsp.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_window_limits();
		test_window_shrink();
		test_random_traffic();
		quiesce();
		repeat (16) @(posedge clk);
		if (rsp_due.size() != 0)
			note_failure($sformatf("%0d responses never arrived", rsp_due.size()));
		$display("Ran %0d events: %0d sends taken, %0d refused, %0d window slides, %0d timeouts",
			n_items, n_sent, n_refused, n_slides, n_timeouts);
		$display("Checked %0d responses, longest burst %0d, %0d window writes, %0d failures",
			n_results, max_burst, n_cfg, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
